// ----- hdl/vls_pkg.sv -----
`timescale 1ns / 1ps

package vls_pkg;

    // field widths
    localparam int VEC_W = 32;
    localparam int CNT_W = 16;
    localparam int FUNC_W = 2;

    // request kinds carried on tuser
    localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

    // packed stream widths
    localparam int AXES     = 3;
    localparam int DATA_W   = 2 * AXES * VEC_W + CNT_W;
    localparam int S_USER_W = FUNC_W;
    localparam int M_USER_W = 2;

    // divider retires two quotient bits per cycle
    localparam int DIV_STEPS = VEC_W / 2;
    localparam int STEP_W    = $clog2(DIV_STEPS);
    localparam int AXIS_W    = $clog2(AXES);

endpackage

// ----- hdl/vector_linear_stepper.sv -----
`timescale 1ns / 1ps

// channel   dir  ports                         contents
// s_axis    in   tvalid tready tdata tuser     start/tick/clear request
// m_axis    out  tvalid tready tdata tuser     position, step, frame count
//
// a start request with a nonzero frame count is accepted, each of the three axes is
// loaded and divided in turn by one shared 2-bit-per-cycle divider, then the result
// is published; tick, clear and zero-count start go from accept straight to publish
// the result sits in an output register, so the next request is taken
// while it waits; a result not yet taken holds the sequencer in its last state
// reset is synchronous, active low, and zeroes all vectors and the frame count

module vector_linear_stepper
    import vls_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // goal_x, goal_y, goal_z, begin_x, begin_y, begin_z, frame_count
    input  logic [DATA_W-1:0]   s_axis_tdata,
    // func
    input  logic [S_USER_W-1:0] s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // pos_x, pos_y, pos_z, delta_x, delta_y, delta_z, frames_left
    output logic [DATA_W-1:0]   m_axis_tdata,
    // moved, done_res
    output logic [M_USER_W-1:0] m_axis_tuser
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LOAD = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]          state_reg, state_next;
    logic [VEC_W-1:0]    goal_reg [AXES];
    logic [VEC_W-1:0]    goal_next [AXES];
    logic [VEC_W-1:0]    pos_reg [AXES];
    logic [VEC_W-1:0]    pos_next [AXES];
    logic [VEC_W-1:0]    delta_reg [AXES];
    logic [VEC_W-1:0]    delta_next [AXES];
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                moved_reg, moved_next;
    logic [AXIS_W-1:0]   axis_reg, axis_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [VEC_W-1:0]    num_reg, num_next;
    logic [CNT_W-1:0]    rem_reg, rem_next;
    logic                neg_reg, neg_next;
    logic                m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]   m_data_reg, m_data_next;
    logic [M_USER_W-1:0] m_user_reg, m_user_next;

    logic                s_req;
    logic                out_free;
    logic [VEC_W-1:0]    diff;
    logic [CNT_W:0]      div_r1, div_r2, div_t1, div_t2;
    logic                div_ge1, div_ge2;
    logic [CNT_W:0]      div_rem1, div_rem2;
    logic [VEC_W-1:0]    div_quo;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_req         = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    // difference of the axis being loaded; pos holds begin during division
    assign diff = goal_reg[axis_reg] - pos_reg[axis_reg];

    // two restoring steps of the shared divider
    assign div_r1   = {rem_reg, num_reg[VEC_W-1]};
    assign div_t1   = div_r1 - {1'b0, cnt_reg};
    assign div_ge1  = (div_r1 >= {1'b0, cnt_reg});
    assign div_rem1 = div_ge1 ? div_t1 : div_r1;
    assign div_r2   = {div_rem1[CNT_W-1:0], num_reg[VEC_W-2]};
    assign div_t2   = div_r2 - {1'b0, cnt_reg};
    assign div_ge2  = (div_r2 >= {1'b0, cnt_reg});
    assign div_rem2 = div_ge2 ? div_t2 : div_r2;
    assign div_quo  = {num_reg[VEC_W-3:0], div_ge1, div_ge2};

    // sequencer and datapath next state
    always_comb begin
        state_next   = state_reg;
        goal_next    = goal_reg;
        pos_next     = pos_reg;
        delta_next   = delta_reg;
        cnt_next     = cnt_reg;
        moved_next   = moved_reg;
        axis_next    = axis_reg;
        step_next    = step_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_req) begin
                    moved_next = 1'b0;
                    state_next = ST_FIN;
                    case (s_axis_tuser)
                        FUNC_START: begin
                            for (int i = 0; i < AXES; i++) begin
                                goal_next[i]  = s_axis_tdata[i*VEC_W +: VEC_W];
                                pos_next[i]   = s_axis_tdata[(AXES+i)*VEC_W +: VEC_W];
                                delta_next[i] = '0;
                            end
                            cnt_next  = s_axis_tdata[2*AXES*VEC_W +: CNT_W];
                            axis_next = '0;
                            if (s_axis_tdata[2*AXES*VEC_W +: CNT_W] != '0) begin
                                state_next = ST_LOAD;
                            end
                        end
                        FUNC_TICK: begin
                            if (cnt_reg == '0) begin
                                pos_next = goal_reg;
                            end else begin
                                cnt_next   = cnt_reg - 1'b1;
                                moved_next = 1'b1;
                                for (int i = 0; i < AXES; i++) begin
                                    pos_next[i] = pos_reg[i] + delta_reg[i];
                                end
                            end
                        end
                        FUNC_CLEAR: begin
                            for (int i = 0; i < AXES; i++) begin
                                goal_next[i]  = '0;
                                pos_next[i]   = '0;
                                delta_next[i] = '0;
                            end
                            cnt_next = '0;
                        end
                        default: begin
                            // unused code leaves state alone
                        end
                    endcase
                end
            end
            ST_LOAD: begin
                neg_next   = diff[VEC_W-1];
                num_next   = diff[VEC_W-1] ? (~diff + 1'b1) : diff;
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                num_next  = div_quo;
                rem_next  = div_rem2[CNT_W-1:0];
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    delta_next[axis_reg] = neg_reg ? (~div_quo + 1'b1) : div_quo;
                    if (axis_reg == AXIS_W'(AXES - 1)) begin
                        state_next = ST_FIN;
                    end else begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_FIN: begin
                // publish once the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    for (int i = 0; i < AXES; i++) begin
                        m_data_next[i*VEC_W +: VEC_W]        = pos_reg[i];
                        m_data_next[(AXES+i)*VEC_W +: VEC_W] = delta_reg[i];
                    end
                    m_data_next[2*AXES*VEC_W +: CNT_W] = cnt_reg;
                    m_user_next = {(cnt_reg == '0), moved_reg};
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            moved_reg   <= 1'b0;
            axis_reg    <= '0;
            step_reg    <= '0;
            for (int i = 0; i < AXES; i++) begin
                goal_reg[i]  <= '0;
                pos_reg[i]   <= '0;
                delta_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            moved_reg   <= moved_next;
            axis_reg    <= axis_next;
            step_reg    <= step_next;
            goal_reg    <= goal_next;
            pos_reg     <= pos_next;
            delta_reg   <= delta_next;
        end
    end

    // divider and output payload
    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
    end

    // a tick with frames left uses up exactly one
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_req && s_axis_tuser == FUNC_TICK && cnt_reg != '0)
            |=> (cnt_reg == $past(cnt_reg) - 1'b1))
        else $error("tick did not consume one frame");

    // the divider never runs against a zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD || state_reg == ST_DIV) |-> (cnt_reg != '0))
        else $error("divider active with zero count");

    // done flag agrees with the published frame count
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_user_reg[1] == (m_data_reg[2*AXES*VEC_W +: CNT_W] == '0)))
        else $error("done flag disagrees with frames left");

    // a request is always followed by a busy cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_req |=> !s_axis_tready)
        else $error("request taken without busy cycle");

    // moved is only ever reported for a tick that stepped
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN && moved_reg) |-> ($past(state_reg) != ST_DIV))
        else $error("moved set on a divided start");

endmodule
